// File: src/imh_pkg.sv
package imh_pkg;

  localparam int CAPACITY  = 1024;
  localparam int NUM_ITEMS = 4096;
  localparam int KEY_BITS  = 32;
  localparam int SLOT_W    = $clog2(CAPACITY);
  localparam int ITEM_W    = $clog2(NUM_ITEMS);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [ITEM_W-1:0]   item_t;
  typedef logic [COUNT_W-1:0]  count_t;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_LOWER   = 2'd1,
    OP_EXTRACT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_PRESENT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_RD_VALID,
    CMD_INS_WR,
    CMD_LOW_WR,
    CMD_EXT_RD,
    CMD_EXT_WR,
    CMD_UP_RD,
    CMD_UP_CMP,
    CMD_DN_RD,
    CMD_DN_CMP,
    CMD_SWAP_A,
    CMD_SWAP_B
  } cmd_t;

  typedef struct packed {
    logic    clr_done;
    logic    valid_ok;
    logic    count_zero;
    logic    count_full;
    logic    up_done;
    logic    up_swap;
    logic    dn_done;
    logic    dn_swap;
  } stat_t;

endpackage

// File: src/imh_if.sv
interface imh_in_if;
  import imh_pkg::*;
  logic  valid;
  logic  ready;
  logic [1:0] op;
  key_t  key;
  item_t item_id;
  modport source (output valid, op, key, item_id, input ready);
  modport sink (input valid, op, key, item_id, output ready);
endinterface

interface imh_out_if;
  import imh_pkg::*;
  logic    valid;
  logic    ready;
  key_t    result_key;
  item_t   result_item;
  logic [2:0] status;
  count_t  count;
  logic    item_present;
  modport source (output valid, result_key, result_item, status, count, item_present,
                  input ready);
  modport sink (input valid, result_key, result_item, status, count, item_present,
                output ready);
endinterface

// File: src/imh_datapath.sv
module imh_datapath
  import imh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       cmd,
  input  logic [1:0] in_op,
  input  key_t       in_key,
  input  item_t      in_item,
  output stat_t      stat,
  output key_t       res_key,
  output item_t      res_item,
  output count_t     res_count,
  output logic [1:0] op_q,
  output logic       present
);

  key_t  slot_keys  [CAPACITY];
  item_t slot_items [CAPACITY];
  slot_t item_slots [NUM_ITEMS];
  logic  item_valid [NUM_ITEMS];

  key_t   key_r, ka_r, kb_r, kc_r;
  item_t  id_r, ia_r, ib_r, ic_r;
  slot_t  pos_r, oth_r;
  count_t cnt_r;
  item_t  clr_r;
  logic   v_r;
  logic [1:0] op_r;
  logic   c2ok_r;
  logic [SLOT_W:0] c1_w;

  assign c1_w = {pos_r, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clr_r <= '0;
    end else begin
      case (cmd)
        CMD_INS_WR: cnt_r <= cnt_r + 1'b1;
        CMD_EXT_WR: cnt_r <= cnt_r - 1'b1;
        CMD_CLEAR:  clr_r <= clr_r + 1'b1;
        default: ;
      endcase
    end
  end

  // clear presence flags one per cycle after reset; extract drops its own flag
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_CLEAR: begin
        item_valid[clr_r] <= 1'b0;
      end
      CMD_LOAD: begin
        op_r <= in_op;
        key_r <= in_key;
        id_r <= in_item;
        res_key <= '0;
        res_item <= '0;
      end
      CMD_RD_VALID: begin
        v_r <= item_valid[id_r];
        pos_r <= item_slots[id_r];
      end
      CMD_INS_WR: begin
        slot_keys[cnt_r[SLOT_W-1:0]] <= key_r;
        slot_items[cnt_r[SLOT_W-1:0]] <= id_r;
        item_slots[id_r] <= cnt_r[SLOT_W-1:0];
        item_valid[id_r] <= 1'b1;
        v_r <= 1'b1;
        pos_r <= cnt_r[SLOT_W-1:0];
        ka_r <= key_r;
        ia_r <= id_r;
      end
      CMD_LOW_WR: begin
        slot_keys[pos_r] <= key_r;
        ka_r <= key_r;
        ia_r <= id_r;
      end
      CMD_EXT_RD: begin
        res_key <= slot_keys[0];
        res_item <= slot_items[0];
        ka_r <= slot_keys[cnt_r[SLOT_W-1:0] - 1'b1];
        ia_r <= slot_items[cnt_r[SLOT_W-1:0] - 1'b1];
      end
      CMD_EXT_WR: begin
        item_valid[res_item] <= 1'b0;
        slot_keys[0] <= ka_r;
        slot_items[0] <= ia_r;
        item_slots[ia_r] <= '0;
        pos_r <= '0;
        v_r <= 1'b0;
      end
      CMD_UP_RD: begin
        oth_r <= slot_t'((pos_r - 1'b1) >> 1);
        kb_r <= slot_keys[slot_t'((pos_r - 1'b1) >> 1)];
        ib_r <= slot_items[slot_t'((pos_r - 1'b1) >> 1)];
      end
      CMD_DN_RD: begin
        kb_r <= slot_keys[c1_w[SLOT_W-1:0]];
        ib_r <= slot_items[c1_w[SLOT_W-1:0]];
        kc_r <= slot_keys[c1_w[SLOT_W-1:0] + 1'b1];
        ic_r <= slot_items[c1_w[SLOT_W-1:0] + 1'b1];
        c2ok_r <= ({1'b0, c1_w} + 1'b1) < {1'b0, cnt_r};
      end
      CMD_DN_CMP: begin
        if (c2ok_r && kc_r < kb_r) begin
          kb_r <= kc_r;
          ib_r <= ic_r;
          oth_r <= c1_w[SLOT_W-1:0] + 1'b1;
        end else begin
          oth_r <= c1_w[SLOT_W-1:0];
        end
      end
      CMD_SWAP_A: begin
        slot_keys[pos_r] <= kb_r;
        slot_items[pos_r] <= ib_r;
        item_slots[ib_r] <= pos_r;
      end
      CMD_SWAP_B: begin
        slot_keys[oth_r] <= ka_r;
        slot_items[oth_r] <= ia_r;
        item_slots[ia_r] <= oth_r;
        pos_r <= oth_r;
      end
      default: ;
    endcase
  end

  assign stat.clr_done   = (clr_r == '1);
  assign stat.valid_ok   = v_r;
  assign stat.count_zero = (cnt_r == '0);
  assign stat.count_full = (cnt_r >= count_t'(CAPACITY));
  assign stat.up_done    = (pos_r == '0);
  assign stat.up_swap    = (ka_r < kb_r);
  assign stat.dn_done    = ({1'b0, c1_w} >= {1'b0, cnt_r});
  assign stat.dn_swap    = (kb_r < ka_r);
  assign res_count = cnt_r;
  assign op_q      = op_r;
  assign present   = v_r;

endmodule

// File: src/imh_ctrl.sv
module imh_ctrl
  import imh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic       out_fire,
  input  stat_t      stat,
  input  logic [1:0] op_q,
  input  logic       id_in_range,
  output cmd_t       cmd,
  output logic       busy,
  output logic       done,
  output status_t    status
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_VALID, S_DECIDE, S_EXT_RD, S_EXT_WR, S_UP_RD, S_UP_CMP,
    S_DN_RD, S_DN_CMP, S_DN_DEC, S_SWAP_A, S_SWAP_B, S_DONE
  } state_t;

  state_t state_r;
  logic   down_r;
  status_t st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      down_r <= 1'b0;
      st_r <= ST_OK;
    end else begin
      case (state_r)
        S_CLEAR: if (stat.clr_done) state_r <= S_IDLE;
        S_IDLE: if (in_fire) state_r <= S_VALID;
        S_VALID: state_r <= S_DECIDE;
        S_DECIDE: begin
          st_r <= ST_OK;
          case (op_q)
            OP_INSERT: begin
              if (!id_in_range) begin st_r <= ST_ABSENT; state_r <= S_DONE; end
              else if (stat.valid_ok) begin st_r <= ST_PRESENT; state_r <= S_DONE; end
              else if (stat.count_full) begin st_r <= ST_FULL; state_r <= S_DONE; end
              else begin down_r <= 1'b0; state_r <= S_UP_RD; end
            end
            OP_LOWER: begin
              if (!id_in_range || !stat.valid_ok) begin
                st_r <= ST_ABSENT; state_r <= S_DONE;
              end else begin down_r <= 1'b0; state_r <= S_UP_RD; end
            end
            OP_EXTRACT: begin
              if (stat.count_zero) begin st_r <= ST_EMPTY; state_r <= S_DONE; end
              else state_r <= S_EXT_RD;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_EXT_RD: state_r <= S_EXT_WR;
        S_EXT_WR: begin down_r <= 1'b1; state_r <= S_DN_RD; end
        S_UP_RD: state_r <= stat.up_done ? S_DONE : S_UP_CMP;
        S_UP_CMP: state_r <= stat.up_swap ? S_SWAP_A : S_DONE;
        S_DN_RD: state_r <= stat.dn_done ? S_DONE : S_DN_CMP;
        S_DN_CMP: state_r <= S_DN_DEC;
        S_DN_DEC: state_r <= stat.dn_swap ? S_SWAP_A : S_DONE;
        S_SWAP_A: state_r <= S_SWAP_B;
        S_SWAP_B: state_r <= down_r ? S_DN_RD : S_UP_RD;
        S_DONE: if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = CMD_IDLE;
    case (state_r)
      S_CLEAR:  cmd = CMD_CLEAR;
      S_IDLE:   cmd = in_fire ? CMD_LOAD : CMD_IDLE;
      S_VALID:  cmd = CMD_RD_VALID;
      S_DECIDE: begin
        if (op_q == OP_INSERT && id_in_range && !stat.valid_ok && !stat.count_full)
          cmd = CMD_INS_WR;
        else if (op_q == OP_LOWER && id_in_range && stat.valid_ok)
          cmd = CMD_LOW_WR;
      end
      S_EXT_RD: cmd = CMD_EXT_RD;
      S_EXT_WR: cmd = CMD_EXT_WR;
      S_UP_RD:  cmd = stat.up_done ? CMD_IDLE : CMD_UP_RD;
      S_DN_RD:  cmd = stat.dn_done ? CMD_IDLE : CMD_DN_RD;
      S_DN_CMP: cmd = CMD_DN_CMP;
      S_SWAP_A: cmd = CMD_SWAP_A;
      S_SWAP_B: cmd = CMD_SWAP_B;
      default:  cmd = CMD_IDLE;
    endcase
  end

  assign busy   = (state_r != S_IDLE);
  assign done   = (state_r == S_DONE);
  assign status = st_r;

  a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP_A |=> state_r == S_SWAP_B)
    else $error("swap halves split");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_fire) |=> state_r == S_DONE)
    else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_fire)
    else $error("accept while busy");

endmodule

// File: src/indexed_min_heap.sv
// channel  dir  payload
// in_      in   op, key, item_id
// out_     out  result_key, result_item, status, count, item_present
// One item at a time. Insert and lower move the item up the heap; extract
// moves the last item to the root and then down, swapping one level at a time.
// Synchronous active-low reset clears count and control, then a pass clears
// all 4096 presence flags with input ready low. The result waits in an output
// register, so one more item may run; a second finished result waits in the
// controller and blocks the input.
module indexed_min_heap
  import imh_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  imh_in_if.sink   in_ch,
  imh_out_if.source out_ch
);

  cmd_t       cmd;
  stat_t      stat;
  logic       busy, done, present, in_fire, out_fire, out_load;
  logic [1:0] op_q;
  status_t    status;
  key_t       res_key;
  item_t      res_item;
  count_t     res_count;
  logic       out_v_r;
  key_t       okey_r;
  item_t      oitem_r;
  status_t    ostat_r;
  count_t     ocount_r;
  logic       opres_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !busy;
  assign out_load = done && (!out_v_r || out_fire);

  imh_datapath u_dp (
    .clk, .rst_n, .cmd,
    .in_op(in_ch.op), .in_key(in_ch.key), .in_item(in_ch.item_id),
    .stat, .res_key, .res_item, .res_count, .op_q, .present
  );

  imh_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire(out_load), .stat, .op_q, .id_in_range(1'b1),
    .cmd, .busy, .done, .status
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      okey_r   <= res_key;
      oitem_r  <= res_item;
      ostat_r  <= status;
      ocount_r <= res_count;
      opres_r  <= (op_q == OP_EXTRACT) ? 1'b0 : present;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_key   = okey_r;
  assign out_ch.result_item  = oitem_r;
  assign out_ch.status       = ostat_r;
  assign out_ch.count        = ocount_r;
  assign out_ch.item_present = opres_r;

endmodule
